@@ rtl/core/base64_stream_decoder_unit_macros.svh @@
// Assertion macros shared by the verification side of the decoder.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64SD_AT_ONCE(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64sd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64SD_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64sd: next-cycle check failed");

`endif

@@ rtl/core/b64sd_pkg.sv @@
package b64sd_pkg;

	// Character codes used by the classifier.
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHR_PLUS    = 8'h2B;
	localparam logic [7:0] CHR_SLASH   = 8'h2F;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;

	localparam logic [7:0] LOWER_BASE = 8'd26;
	localparam logic [7:0] DIGIT_BASE = 8'd52;
	localparam logic [5:0] SX_PLUS    = 6'(2 * 26 + 10);
	localparam logic [5:0] SX_SLASH   = 6'(2 * 26 + 11);

	// Depth of the queue between the front and back parts.
	localparam int CMD_DEPTH = 4;

	typedef enum logic {
		CMD_ZERO,
		CMD_GROUP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        closes;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        run_last;
		logic        finished;
		logic        status;
		logic [23:0] decoded_count;
	} result_t;

	typedef struct packed {
		logic       is_sym;
		logic       is_pad;
		logic [5:0] sx;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r = '0;
		if (c inside {[CHR_UPPER_A:CHR_UPPER_Z]}) begin
			r.is_sym = 1'b1;
			r.sx = 6'(c - CHR_UPPER_A);
		end else if (c inside {[CHR_LOWER_A:CHR_LOWER_Z]}) begin
			r.is_sym = 1'b1;
			r.sx = 6'(c - CHR_LOWER_A + LOWER_BASE);
		end else if (c inside {[CHR_DIGIT_0:CHR_DIGIT_9]}) begin
			r.is_sym = 1'b1;
			r.sx = 6'(c - CHR_DIGIT_0 + DIGIT_BASE);
		end else if (c == CHR_PLUS) begin
			r.is_sym = 1'b1;
			r.sx = SX_PLUS;
		end else if (c == CHR_SLASH) begin
			r.is_sym = 1'b1;
			r.sx = SX_SLASH;
		end else if (c == PAD_CHAR) begin
			r.is_pad = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/b64sd_front.sv @@
module b64sd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_in,
	input  logic                final_char,
	output logic                cmd_push,
	output b64sd_pkg::cmd_t     cmd
);

	logic [17:0] acc_q;
	logic [1:0]  fill_q;
	logic [1:0]  pad_q;
	logic        bad_q;
	logic        stop_q;

	b64sd_pkg::char_class_t cls;
	logic        kept;
	logic [2:0]  npad_a;
	logic        bad_a;
	logic [17:0] acc1;
	logic [1:0]  fill1;
	logic [1:0]  pad1;
	logic        bad1;
	logic        done_a;
	logic [23:0] word_a;
	logic [1:0]  n_a;
	logic [2:0]  pads_b;
	logic [2:0]  npad_b;
	logic [23:0] word_b;
	logic [1:0]  n_b;
	logic        stop_n;

	// Add the incoming character to the open group.
	always_comb begin
		cls    = b64sd_pkg::classify(char_in);
		kept   = cls.is_sym | cls.is_pad;
		npad_a = {1'b0, pad_q} + {2'b00, cls.is_pad};
		bad_a  = bad_q | (cls.is_sym & (pad_q != 2'd0));
		acc1   = acc_q;
		fill1  = fill_q;
		pad1   = pad_q;
		bad1   = bad_q;
		done_a = 1'b0;
		word_a = '0;
		n_a    = 2'd0;
		if (kept) begin
			if (fill_q != 2'd3) begin
				acc1  = {acc_q[11:0], cls.sx};
				fill1 = fill_q + 2'd1;
				pad1  = npad_a[1:0];
				bad1  = bad_a;
			end else begin
				done_a = 1'b1;
				word_a = {acc_q, cls.sx};
				n_a    = (bad_a || npad_a >= 3'd3) ? 2'd0 : 2'(3'd3 - npad_a);
				acc1   = '0;
				fill1  = 2'd0;
				pad1   = 2'd0;
				bad1   = 1'b0;
			end
		end
	end

	// Close a partial group with padding, for the final character.
	always_comb begin
		pads_b = 3'd4 - {1'b0, fill1};
		npad_b = {1'b0, pad1} + pads_b;
		case (fill1)
			2'd1:    word_b = {acc1[5:0], 18'd0};
			2'd2:    word_b = {acc1[11:0], 12'd0};
			2'd3:    word_b = {acc1, 6'd0};
			default: word_b = '0;
		endcase
		n_b = (bad1 || npad_b >= 3'd3) ? 2'd0 : 2'(3'd3 - npad_b);
	end

	// Turn the outcome into at most one command for the back part.
	always_comb begin
		cmd_push = 1'b0;
		cmd      = '0;
		stop_n   = stop_q;
		if (accept && !stop_q) begin
			if (done_a && n_a != 2'd3) begin
				cmd_push = 1'b1;
				stop_n   = 1'b1;
				if (n_a == 2'd0) begin
					cmd.kind = b64sd_pkg::CMD_ZERO;
				end else begin
					cmd.kind   = b64sd_pkg::CMD_GROUP;
					cmd.word   = word_a;
					cmd.nbytes = n_a;
					cmd.closes = 1'b1;
				end
			end else if (final_char) begin
				cmd_push = 1'b1;
				stop_n   = 1'b1;
				if (fill1 == 2'd0) begin
					if (done_a) begin
						// A full group followed by an empty padded one.
						cmd.kind   = b64sd_pkg::CMD_GROUP;
						cmd.word   = word_a;
						cmd.nbytes = 2'd3;
						cmd.closes = 1'b1;
					end else begin
						cmd.kind = b64sd_pkg::CMD_ZERO;
					end
				end else if (n_b == 2'd0) begin
					cmd.kind = b64sd_pkg::CMD_ZERO;
				end else begin
					cmd.kind   = b64sd_pkg::CMD_GROUP;
					cmd.word   = word_b;
					cmd.nbytes = n_b;
					cmd.closes = 1'b1;
				end
			end else if (done_a) begin
				cmd_push   = 1'b1;
				cmd.kind   = b64sd_pkg::CMD_GROUP;
				cmd.word   = word_a;
				cmd.nbytes = 2'd3;
				cmd.closes = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= 2'd0;
			pad_q  <= 2'd0;
			bad_q  <= 1'b0;
			stop_q <= 1'b0;
		end else if (accept && !stop_q) begin
			acc_q  <= acc1;
			fill_q <= fill1;
			pad_q  <= pad1;
			bad_q  <= bad1;
			stop_q <= stop_n;
		end
	end

endmodule

@@ rtl/core/b64sd_cmd_fifo.sv @@
module b64sd_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64sd_pkg::cmd_t wdata,
	output logic            full,
	input  logic            pop,
	output b64sd_pkg::cmd_t rdata,
	output logic            empty
);

	localparam int PW = $clog2(b64sd_pkg::CMD_DEPTH);
	localparam int CNW = $clog2(b64sd_pkg::CMD_DEPTH + 1);

	b64sd_pkg::cmd_t   mem_q [b64sd_pkg::CMD_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CNW-1:0]    cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == CNW'(b64sd_pkg::CMD_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

endmodule

@@ rtl/core/b64sd_back.sv @@
module b64sd_back #(
	parameter int COUNT_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [23:0]        cfg_wr_data,
	input  logic               cmd_valid,
	input  b64sd_pkg::cmd_t    cmd,
	output logic               cmd_pop,
	output b64sd_pkg::result_t res,
	output logic               empty,
	input  logic               pop
);

	localparam int CW = ((COUNT_BITS > 24) ? COUNT_BITS : 24) + 2;
	localparam logic [CW-1:0] CAP = (CW'(1) << COUNT_BITS) - CW'(1);

	logic [23:0]           limit_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [1:0]            idx_q;
	logic                  stop_q;
	logic                  ovf_q;

	b64sd_pkg::result_t    ofifo_q [2];
	logic                  owr_q;
	logic                  ord_q;
	logic [1:0]            ocnt_q;

	logic                  room;
	logic [CW-1:0]         limit_w;
	logic [CW-1:0]         lim_eff;
	logic [CW-1:0]         sum_w;
	logic                  over;
	logic [COUNT_BITS-1:0] total_inc;
	logic                  last;
	logic [7:0]            sel_byte;
	logic                  res_push;
	b64sd_pkg::result_t    res_new;
	logic [1:0]            idx_n;
	logic [COUNT_BITS-1:0] total_n;
	logic                  stop_n;
	logic                  ovf_n;
	logic                  do_opop;

	always_comb begin
		room      = (ocnt_q != 2'd2);
		limit_w   = CW'(limit_q);
		lim_eff   = (limit_w > CAP) ? CAP : limit_w;
		sum_w     = CW'(total_q) + CW'(cmd.nbytes);
		over      = (idx_q == 2'd0) && (sum_w > lim_eff);
		total_inc = total_q + COUNT_BITS'(1);
		last      = (idx_q == (cmd.nbytes - 2'd1));
		case (idx_q)
			2'd0:    sel_byte = cmd.word[23:16];
			2'd1:    sel_byte = cmd.word[15:8];
			default: sel_byte = cmd.word[7:0];
		endcase
	end

	// One result per cycle, while the result queue has room, from the command at the head of the queue.
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_new  = '0;
		idx_n    = idx_q;
		total_n  = total_q;
		stop_n   = stop_q;
		ovf_n    = ovf_q;
		if (cmd_valid) begin
			if (stop_q) begin
				cmd_pop = 1'b1;
			end else if (room) begin
				res_push = 1'b1;
				case (cmd.kind)
					b64sd_pkg::CMD_ZERO: begin
						cmd_pop               = 1'b1;
						stop_n                = 1'b1;
						idx_n                 = 2'd0;
						res_new.run_last      = 1'b1;
						res_new.finished      = 1'b1;
						res_new.status        = ovf_q;
						res_new.decoded_count = 24'(total_q);
					end
					b64sd_pkg::CMD_GROUP: begin
						if (over) begin
							cmd_pop               = 1'b1;
							stop_n                = 1'b1;
							ovf_n                 = 1'b1;
							idx_n                 = 2'd0;
							res_new.run_last      = 1'b1;
							res_new.finished      = 1'b1;
							res_new.status        = 1'b1;
							res_new.decoded_count = 24'(total_q);
						end else begin
							total_n               = total_inc;
							res_new.out_byte      = sel_byte;
							res_new.byte_valid    = 1'b1;
							res_new.run_last      = last;
							res_new.finished      = last && cmd.closes;
							res_new.status        = ovf_q;
							res_new.decoded_count = 24'(total_inc);
							if (last) begin
								cmd_pop = 1'b1;
								idx_n   = 2'd0;
								stop_n  = cmd.closes;
							end else begin
								idx_n = idx_q + 2'd1;
							end
						end
					end
					default: begin
						cmd_pop  = 1'b1;
						res_push = 1'b0;
					end
				endcase
			end
		end
	end

	assign empty   = (ocnt_q == 2'd0);
	assign do_opop = pop && !empty;
	assign res     = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			ofifo_q[owr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 24'hFFFFFF;
			total_q <= '0;
			idx_q   <= 2'd0;
			stop_q  <= 1'b0;
			ovf_q   <= 1'b0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			total_q <= total_n;
			idx_q   <= idx_n;
			stop_q  <= stop_n;
			ovf_q   <= ovf_n;
			if (res_push) begin
				owr_q <= ~owr_q;
			end
			if (do_opop) begin
				ord_q <= ~ord_q;
			end
			if (res_push && !do_opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (do_opop && !res_push) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/core/base64_stream_decoder_unit.sv @@
// Streaming Base64 decoder. Source characters enter one word at a time on the
// input queue port (push/full, char_in, final_char); decoded bytes and status
// leave on the result queue port (empty/pop and the result fields).
// The output limit register is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle, which it does not enforce;
// it takes effect for the next group that is checked. Each input word causes
// zero to three result words, and the last of them carries run_last. The word
// that closes the decode carries finished, and every word after that is ignored
// until reset. A character that completes a group is written into the command
// queue; its results go through the registered result queue to the ports.
// Throughput: one character per cycle on the input while full is low. The
// back part emits one result word per cycle while the result queue has room,
// one per decoded byte; a four-entry command queue holds commands meanwhile.
// Reset clears the group state, the byte total and both queues, and sets the
// output limit to its maximum. There is no clearing pass after reset.
// When the receiver stalls, the two-entry result queue fills, the back part
// stops draining commands, and full rises once the command queue is full.
module base64_stream_decoder_unit #(
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_in,
	input  logic        final_char,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        finished,
	output logic        status,
	output logic [23:0] decoded_count
);

	logic               accept;
	logic               cmd_push;
	b64sd_pkg::cmd_t    cmd_in;
	b64sd_pkg::cmd_t    cmd_head;
	logic               cmd_empty;
	logic               cmd_pop;
	b64sd_pkg::result_t res;

	// The front part takes a character whenever the command queue has room.
	assign accept = push && !full;

	b64sd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_in    (char_in),
		.final_char (final_char),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	b64sd_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	b64sd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (!cmd_empty),
		.cmd         (cmd_head),
		.cmd_pop     (cmd_pop),
		.res         (res),
		.empty       (empty),
		.pop         (pop)
	);

	assign out_byte      = res.out_byte;
	assign byte_valid    = res.byte_valid;
	assign run_last      = res.run_last;
	assign finished      = res.finished;
	assign status        = res.status;
	assign decoded_count = res.decoded_count;

endmodule

@@ rtl/core/b64sd_checker.sv @@
`include "base64_stream_decoder_unit_macros.svh"

module b64sd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        run_last,
	input logic        finished,
	input logic        status,
	input logic [23:0] decoded_count
);

	// Nothing follows the word that closes the decode.
	`B64SD_NEXT(a_quiet_after_finish, pop && !empty && finished, empty)

	// An overflow word carries no byte and closes the decode.
	`B64SD_AT_ONCE(a_overflow_closes, !empty && status, finished && run_last && !byte_valid)

	// A word without a byte only ever appears as the closing word.
	`B64SD_AT_ONCE(a_no_byte_closes, !empty && !byte_valid, finished && run_last)

	// A result that is not taken stays on the ports unchanged.
	`B64SD_NEXT(a_stall_holds, !empty && !pop, !empty && $stable({out_byte, decoded_count, finished}))

endmodule

bind base64_stream_decoder_unit b64sd_checker u_b64sd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.out_byte      (out_byte),
	.byte_valid    (byte_valid),
	.run_last      (run_last),
	.finished      (finished),
	.status        (status),
	.decoded_count (decoded_count)
);

@@ test/base64_stream_decoder_unit_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the streaming Base64 decoder.
// The block keeps decoding until it sees padding, a final character or an
// overflow, and after that it ignores everything until reset. Since reset is
// applied only once, a run is one long decode: many full groups first, and
// then one closing sequence picked at random from the ways a decode can end.
// The predictor below tracks the group state and turns every accepted word
// into the result words the block must produce.
module base64_stream_decoder_unit_tb;

	localparam int NOT_IN_ALPHABET = -1;
	// Cycles to let pass after the last expected result before a register
	// write, so that words which cause no result have left the pipeline.
	localparam int SETTLE_CYCLES = 8;
	localparam logic [23:0] LIMIT_MAX = 24'hFFFFFF;

	// The ways the single decode of a run can be closed.
	typedef enum int {
		END_FULL_FINAL,
		END_ONE_FINAL,
		END_TWO_FINAL,
		END_THREE_FINAL,
		END_NOISE_FINAL,
		END_TWO_PAD,
		END_ONE_PAD,
		END_THREE_PAD,
		END_FOUR_PAD,
		END_PAD_FINAL,
		END_MISPLACED_EARLY,
		END_MISPLACED_LATE,
		END_OVERFLOW,
		END_COUNT
	} ending_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} source_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  char_in = '0;
	logic        final_char = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        finished;
	logic        status;
	logic [23:0] decoded_count;

	base64_stream_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.final_char   (final_char),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.finished     (finished),
		.status       (status),
		.decoded_count(decoded_count)
	);

	always #5 clk = ~clk;

	// Characters waiting for the driver, and the result words still owed.
	source_char_t       pending_chars[$];
	b64sd_pkg::result_t owed_results[$];

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int mismatch_count = 0;
	// Alphabet characters queued so far; used only to line up group borders.
	int kept_queued = 0;

	// Decoder state as the predictor sees it.
	logic [17:0] sextets = '0;
	int          group_fill = 0;
	int          pads_seen = 0;
	logic        group_broken = 1'b0;
	logic        decode_done = 1'b0;
	logic        limit_hit = 1'b0;
	int          bytes_total = 0;
	int          limit_copy = int'(LIMIT_MAX);

	// Results of the character being decoded; at most three per word.
	b64sd_pkg::result_t step_results[0:2];
	int                 step_count = 0;

	// Neighbors of every alphabet range and of the pad character, plus the
	// corners of the alphabet itself and the all-ones and all-zeros groups.
	logic [7:0] boundary_chars[0:22] = '{
		b64sd_pkg::CHR_PLUS, 8'h7F, b64sd_pkg::CHR_DIGIT_9,
		b64sd_pkg::CHR_UPPER_Z, b64sd_pkg::CHR_LOWER_A, b64sd_pkg::CHR_DIGIT_0,
		b64sd_pkg::CHR_SLASH,
		8'h80, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h3A, 8'h3C, 8'h3E,
		b64sd_pkg::CHR_SLASH, b64sd_pkg::CHR_SLASH,
		b64sd_pkg::CHR_SLASH, b64sd_pkg::CHR_SLASH,
		b64sd_pkg::CHR_UPPER_A, b64sd_pkg::CHR_UPPER_A,
		b64sd_pkg::CHR_UPPER_A, b64sd_pkg::CHR_UPPER_A
	};

	function automatic int sextet_of_char(input logic [7:0] c);
		if (c >= b64sd_pkg::CHR_UPPER_A && c <= b64sd_pkg::CHR_UPPER_Z)
			return int'(c - b64sd_pkg::CHR_UPPER_A);
		if (c >= b64sd_pkg::CHR_LOWER_A && c <= b64sd_pkg::CHR_LOWER_Z)
			return int'(c - b64sd_pkg::CHR_LOWER_A) + 26;
		if (c >= b64sd_pkg::CHR_DIGIT_0 && c <= b64sd_pkg::CHR_DIGIT_9)
			return int'(c - b64sd_pkg::CHR_DIGIT_0) + 52;
		if (c == b64sd_pkg::CHR_PLUS)
			return int'(b64sd_pkg::SX_PLUS);
		if (c == b64sd_pkg::CHR_SLASH)
			return int'(b64sd_pkg::SX_SLASH);
		return NOT_IN_ALPHABET;
	endfunction

	function automatic logic [7:0] char_of_sextet(input int sx);
		if (sx < 26)
			return b64sd_pkg::CHR_UPPER_A + 8'(sx);
		if (sx < 52)
			return b64sd_pkg::CHR_LOWER_A + 8'(sx - 26);
		if (sx < 62)
			return b64sd_pkg::CHR_DIGIT_0 + 8'(sx - 52);
		if (sx == int'(b64sd_pkg::SX_PLUS))
			return b64sd_pkg::CHR_PLUS;
		return b64sd_pkg::CHR_SLASH;
	endfunction

	function automatic void emit_result(input logic [7:0] b, input logic valid,
			input logic closes);
		b64sd_pkg::result_t r;
		r.out_byte = valid ? b : 8'h00;
		r.byte_valid = valid;
		r.run_last = 1'b0;
		r.finished = closes;
		r.status = limit_hit;
		r.decoded_count = bytes_total[23:0];
		step_results[step_count] = r;
		step_count++;
	endfunction

	// One kept symbol: a sextet, or a pad that counts as a zero sextet.
	function automatic void take_symbol(input logic [5:0] sx, input logic is_pad);
		int npad;
		int nbytes;
		logic [23:0] group_word;
		npad = pads_seen + (is_pad ? 1 : 0);
		// A data character after a pad spoils the whole group.
		if (!is_pad && pads_seen != 0)
			group_broken = 1'b1;
		if (group_fill < 3) begin
			sextets = {sextets[11:0], sx};
			group_fill++;
			pads_seen = npad;
			return;
		end
		group_word = {sextets, sx};
		nbytes = (group_broken || npad >= 3) ? 0 : 3 - npad;
		sextets = '0;
		group_fill = 0;
		pads_seen = 0;
		group_broken = 1'b0;
		if (nbytes == 0) begin
			// An empty group ends the decode; it rides on a byte of the same
			// word if there is one, else it gets a word of its own.
			decode_done = 1'b1;
			if (step_count > 0)
				step_results[step_count - 1].finished = 1'b1;
			else
				emit_result(8'h00, 1'b0, 1'b1);
			return;
		end
		if (bytes_total + nbytes > limit_copy) begin
			limit_hit = 1'b1;
			decode_done = 1'b1;
			emit_result(8'h00, 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < nbytes; i++) begin
			bytes_total++;
			emit_result(group_word[23 - 8 * i -: 8], 1'b1,
				nbytes < 3 && i == nbytes - 1);
		end
		if (nbytes < 3)
			decode_done = 1'b1;
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic fin);
		int sx;
		if (decode_done)
			return;
		step_count = 0;
		sx = sextet_of_char(c);
		if (sx != NOT_IN_ALPHABET)
			take_symbol(6'(sx), 1'b0);
		else if (c == b64sd_pkg::PAD_CHAR)
			take_symbol(6'd0, 1'b1);
		// The final character pads the open group, or closes an empty one
		// as four pads.
		if (fin)
			for (int i = 0; i < 4 && !decode_done; i++)
				take_symbol(6'd0, 1'b1);
		if (step_count > 0)
			step_results[step_count - 1].run_last = 1'b1;
		for (int i = 0; i < step_count; i++)
			owed_results.push_back(step_results[i]);
	endfunction

	// Driver: a word is accepted at an edge where push is high and full low.
	// A new word goes out only when the slot is free, so the inputs never
	// change under a stalled push.
	always @(posedge clk) begin : driver
		source_char_t next;
		if (arst_n) begin
			if (push && !full)
				decode_char(char_in, final_char);
			if (!push || !full) begin
				if (pending_chars.size() != 0 &&
						$urandom_range(0, 99) >= sender_idle_pct) begin
					next = pending_chars.pop_front();
					push <= 1'b1;
					char_in <= next.ch;
					final_char <= next.fin;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				want, got);
		end
	endtask

	// Monitor: every popped word is checked against the oldest one owed.
	always @(posedge clk) begin : monitor
		b64sd_pkg::result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result word with none expected, actual byte %0h count %0h",
						$time, out_byte, decoded_count);
				end else begin
					want = owed_results.pop_front();
					compare_field("out_byte", 24'(want.out_byte), 24'(out_byte));
					compare_field("byte_valid", 24'(want.byte_valid), 24'(byte_valid));
					compare_field("run_last", 24'(want.run_last), 24'(run_last));
					compare_field("finished", 24'(want.finished), 24'(finished));
					compare_field("status", 24'(want.status), 24'(status));
					compare_field("decoded_count", want.decoded_count, decoded_count);
				end
			end
			pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic add_item(input logic [7:0] c, input logic fin);
		source_char_t item;
		item.ch = c;
		item.fin = fin;
		pending_chars.push_back(item);
		if (sextet_of_char(c) != NOT_IN_ALPHABET)
			kept_queued++;
	endtask

	function automatic logic [7:0] rand_alpha();
		return char_of_sextet($urandom_range(0, 63));
	endfunction

	// Any byte outside the alphabet that is not a pad; the decoder skips it.
	function automatic logic [7:0] rand_noise();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (sextet_of_char(c) != NOT_IN_ALPHABET || c == b64sd_pkg::PAD_CHAR)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// Closing characters, with skipped noise sprinkled in between.
	task automatic add_tail(input logic [7:0] c, input logic fin);
		if ($urandom_range(0, 3) == 0)
			add_item(rand_noise(), 1'b0);
		add_item(c, fin);
	endtask

	// Mostly well-formed text with random content and a fifth of noise.
	task automatic add_random(input int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 20)
				add_item(rand_noise(), 1'b0);
			else
				add_item(rand_alpha(), 1'b0);
		end
	endtask

	// Sampled on the falling edge, where driver and monitor have settled.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_chars.size() != 0 || push || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [23:0] value);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_copy = int'(value);
	endtask

	initial begin : stimulus
		ending_t ending;
		int tail_bytes;
		logic [23:0] closing_limit;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 26;
		receiver_idle_pct = 65;

		// A zero limit matters only when a group completes, so a partial
		// group and noise must pass through without any result.
		write_limit(24'd0);
		add_item(8'h00, 1'b0);
		add_item(b64sd_pkg::CHR_UPPER_A, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(b64sd_pkg::CHR_LOWER_Z, 1'b0);

		write_limit(LIMIT_MAX);
		foreach (boundary_chars[i])
			add_item(boundary_chars[i], 1'b0);
		add_random(45);

		write_limit(24'($urandom_range(bytes_total + 200, 24'hFFFFFE)));
		sender_idle_pct = 65;
		receiver_idle_pct = 26;
		add_random(45);

		write_limit(24'($urandom_range(bytes_total + 200, 24'hFFFFFE)));
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		add_random(45);
		// Close the open group so that every ending starts on a border.
		while (kept_queued % 4 != 0)
			add_item(rand_alpha(), 1'b0);

		wait_idle();
		ending = ending_t'($urandom_range(0, END_COUNT - 1));
		case (ending)
			END_FULL_FINAL, END_OVERFLOW: tail_bytes = 3;
			END_TWO_FINAL, END_TWO_PAD, END_PAD_FINAL: tail_bytes = 1;
			END_THREE_FINAL, END_ONE_PAD: tail_bytes = 2;
			default: tail_bytes = 0;
		endcase
		if (ending == END_OVERFLOW) begin
			// A limit at zero, at or below the total, or just short of the group.
			case ($urandom_range(0, 2))
				0: closing_limit = 24'd0;
				1: closing_limit = 24'($urandom_range(0, bytes_total));
				default: closing_limit = 24'(bytes_total + 2);
			endcase
		end else if ($urandom_range(0, 1) == 0) begin
			closing_limit = 24'(bytes_total + tail_bytes);
		end else begin
			closing_limit = LIMIT_MAX;
		end
		write_limit(closing_limit);

		case (ending)
			END_FULL_FINAL: begin
				// Three bytes and then an empty group in the same word.
				repeat (3) add_tail(rand_alpha(), 1'b0);
				add_tail(rand_alpha(), 1'b1);
			end
			END_ONE_FINAL: add_tail(rand_alpha(), 1'b1);
			END_TWO_FINAL: begin
				add_tail(rand_alpha(), 1'b0);
				add_tail(rand_alpha(), 1'b1);
			end
			END_THREE_FINAL: begin
				repeat (2) add_tail(rand_alpha(), 1'b0);
				add_tail(rand_alpha(), 1'b1);
			end
			END_NOISE_FINAL: add_item(rand_noise(), 1'b1);
			END_TWO_PAD: begin
				repeat (2) add_tail(rand_alpha(), 1'b0);
				repeat (2) add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
			end
			END_ONE_PAD: begin
				repeat (3) add_tail(rand_alpha(), 1'b0);
				add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
			end
			END_THREE_PAD: begin
				add_tail(rand_alpha(), 1'b0);
				repeat (3) add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
			end
			END_FOUR_PAD: repeat (4) add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
			END_PAD_FINAL: begin
				repeat (2) add_tail(rand_alpha(), 1'b0);
				add_tail(b64sd_pkg::PAD_CHAR, 1'b1);
			end
			END_MISPLACED_EARLY: begin
				add_tail(rand_alpha(), 1'b0);
				add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
				repeat (2) add_tail(rand_alpha(), 1'b0);
			end
			END_MISPLACED_LATE: begin
				repeat (2) add_tail(rand_alpha(), 1'b0);
				add_tail(b64sd_pkg::PAD_CHAR, 1'b0);
				add_tail(rand_alpha(), 1'b0);
			end
			default: repeat (4) add_tail(rand_alpha(), 1'b0);
		endcase

		// The decode is over; none of these may cause a result.
		add_item(rand_alpha(), 1'b0);
		add_item(b64sd_pkg::PAD_CHAR, 1'b0);
		add_item(rand_noise(), 1'b0);
		add_item(rand_alpha(), 1'b1);
		repeat (4) add_item(rand_alpha(), 1'b0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && owed_results.size() == 0) begin
			$display("PASS base64_stream_decoder_unit");
		end else begin
			$display("FAIL base64_stream_decoder_unit");
		end
		$finish;
	end

	// A correct run ends well within a tenth of this time.
	initial begin : watchdog
		#2000000;
		$display("FAIL base64_stream_decoder_unit");
		$finish;
	end

endmodule
